/* hdl/bmhq_pkg.sv */
// Package for the binary max-heap priority queue: sizes, request and status
// codes, payload structs and the controller/datapath command and status types.
// No dependencies.
package bmhq_pkg;

	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SLOT_W  = $clog2(DEPTH + 1);
	localparam int CHILD_W = SLOT_W + 1;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 11;
	localparam int WIDE_W  = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_INC  = 2'd2;
	localparam logic [1:0] REQ_PEEK = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SMALLER = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_BADPOS  = 3'd4;

	// read address selection
	localparam logic [1:0] RA_ROOT_LAST = 2'd0;
	localparam logic [1:0] RA_POS       = 2'd1;
	localparam logic [1:0] RA_PARENT    = 2'd2;
	localparam logic [1:0] RA_CHILD     = 2'd3;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] value;
		logic [2:0]              status;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic [1:0] ra_sel;
		logic       push_init;
		logic       pop_init;
		logic       inc_init;
		logic       up_step;
		logic       down_step;
		logic       place;
		logic       peek_load;
		logic       set_status;
		logic [2:0] status;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       empty;
		logic       full;
		logic       pos_bad;
		logic       key_smaller;
		logic       at_root;
		logic       parent_less;
		logic       down_leaf;
		logic       down_move;
	} dp_stat_t;

endpackage

/* hdl/binary_max_heap_queue.sv */
// Binary max-heap priority queue, one result per request; reset empties it, no clearing pass.
// Empty, full and bad-position requests are answered straight from decode; peek and a refused
// increase-key after one memory read; push and increase-key sift up level by level, and pop
// sifts down level by level. One request at a time: the next is taken in the cycle after the
// result loads, even while that result waits.
module binary_max_heap_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bmhq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bmhq_pkg::rsp_t rsp
);
	import bmhq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bmhq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

/* hdl/bmhq_dp.sv */
// Datapath of the heap queue: heap memory, entry count, sift index, held key
// and the result register. Depends on bmhq_pkg.
module bmhq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bmhq_pkg::req_t     req,
	input  bmhq_pkg::dp_cmd_t  cmd,
	output bmhq_pkg::dp_stat_t stat,
	output bmhq_pkg::rsp_t     rsp
);
	import bmhq_pkg::*;

	logic signed [KEY_W-1:0] mem [DEPTH];
	logic signed [KEY_W-1:0] rd0_q, rd1_q;
	logic [SLOT_W-1:0]       cnt_q, idx_q;
	logic [1:0]              type_q;
	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] value_q;
	logic [2:0]              status_q;
	rsp_t                    rsp_q;

	logic [CHILD_W-1:0]      lft, rgt, slot0, slot1;
	logic [ADDR_W-1:0]       addr0, addr1, waddr;
	logic                    wr_en;
	logic signed [KEY_W-1:0] wr_data;
	logic                    l_ok, r_ok, l_win, r_win;
	logic signed [KEY_W-1:0] big_val, child_val;
	logic [SLOT_W-1:0]       child_idx;

	assign lft = {idx_q, 1'b0};
	assign rgt = {idx_q, 1'b1};

	always_comb begin
		case (cmd.ra_sel)
			RA_ROOT_LAST: begin
				slot0 = CHILD_W'(1);
				slot1 = CHILD_W'(cnt_q);
			end
			RA_POS: begin
				slot0 = CHILD_W'(pos_q);
				slot1 = CHILD_W'(pos_q);
			end
			RA_PARENT: begin
				slot0 = CHILD_W'(idx_q >> 1);
				slot1 = CHILD_W'(idx_q >> 1);
			end
			RA_CHILD: begin
				slot0 = lft;
				slot1 = rgt;
			end
			default: begin
				slot0 = CHILD_W'(1);
				slot1 = CHILD_W'(1);
			end
		endcase
	end

	// slots are one-based
	assign addr0 = ADDR_W'(slot0 - CHILD_W'(1));
	assign addr1 = ADDR_W'(slot1 - CHILD_W'(1));
	assign waddr = ADDR_W'(idx_q - SLOT_W'(1));

	// pick the larger child only when it beats the held key
	assign l_ok      = lft <= CHILD_W'(cnt_q);
	assign r_ok      = rgt <= CHILD_W'(cnt_q);
	assign l_win     = l_ok && (key_q < rd0_q);
	assign big_val   = l_win ? rd0_q : key_q;
	assign r_win     = r_ok && (big_val < rd1_q);
	assign child_val = r_win ? rd1_q : rd0_q;
	assign child_idx = r_win ? SLOT_W'(rgt) : SLOT_W'(lft);

	assign wr_en = cmd.up_step | cmd.down_step | cmd.place;

	always_comb begin
		if (cmd.up_step) begin
			wr_data = rd0_q;
		end else if (cmd.down_step) begin
			wr_data = child_val;
		end else begin
			wr_data = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wr_data;
		end
		rd0_q <= mem[addr0];
		rd1_q <= mem[addr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.push_init) begin
			cnt_q <= cnt_q + SLOT_W'(1);
		end else if (cmd.pop_init) begin
			cnt_q <= cnt_q - SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q   <= req.req_type;
			key_q    <= req.key;
			pos_q    <= req.position;
			value_q  <= '0;
			status_q <= ST_OK;
		end
		if (cmd.push_init) begin
			idx_q <= cnt_q + SLOT_W'(1);
		end
		if (cmd.pop_init) begin
			value_q <= rd0_q;
			key_q   <= rd1_q;
			idx_q   <= SLOT_W'(1);
		end
		if (cmd.inc_init) begin
			idx_q <= SLOT_W'(pos_q);
		end
		if (cmd.up_step) begin
			idx_q <= idx_q >> 1;
		end
		if (cmd.down_step) begin
			idx_q <= child_idx;
		end
		if (cmd.peek_load) begin
			value_q <= rd0_q;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.emit) begin
			rsp_q.value  <= value_q;
			rsp_q.status <= status_q;
		end
	end

	assign stat.req_type    = type_q;
	assign stat.empty       = cnt_q == '0;
	assign stat.full        = cnt_q == SLOT_W'(DEPTH);
	assign stat.pos_bad     = (pos_q == '0) || (WIDE_W'(pos_q) > WIDE_W'(cnt_q));
	assign stat.key_smaller = key_q < rd0_q;
	assign stat.at_root     = idx_q == SLOT_W'(1);
	assign stat.parent_less = rd0_q < key_q;
	assign stat.down_leaf   = idx_q >= cnt_q;
	assign stat.down_move   = l_win | r_win;

	assign rsp = rsp_q;

endmodule

/* hdl/bmhq_ctrl.sv */
// Controller of the heap queue: request decode and the sift-up and sift-down
// sequences, plus the result handshake. Depends on bmhq_pkg.
module bmhq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bmhq_pkg::dp_stat_t stat,
	output bmhq_pkg::dp_cmd_t  cmd
);
	import bmhq_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_POP_LD  = 4'd2;
	localparam logic [3:0] S_PEEK_LD = 4'd3;
	localparam logic [3:0] S_INC_CMP = 4'd4;
	localparam logic [3:0] S_UP_CHK  = 4'd5;
	localparam logic [3:0] S_UP_CMP  = 4'd6;
	localparam logic [3:0] S_DN_CHK  = 4'd7;
	localparam logic [3:0] S_DN_CMP  = 4'd8;
	localparam logic [3:0] S_FINISH  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       rsp_valid_q;

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.req_type)
					REQ_PUSH: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
							state_d        = S_FINISH;
						end else begin
							cmd.push_init = 1'b1;
							state_d       = S_UP_CHK;
						end
					end
					REQ_POP: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
							state_d        = S_FINISH;
						end else begin
							cmd.ra_sel = RA_ROOT_LAST;
							state_d    = S_POP_LD;
						end
					end
					REQ_INC: begin
						if (stat.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BADPOS;
							state_d        = S_FINISH;
						end else begin
							cmd.ra_sel = RA_POS;
							state_d    = S_INC_CMP;
						end
					end
					default: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
							state_d        = S_FINISH;
						end else begin
							cmd.ra_sel = RA_ROOT_LAST;
							state_d    = S_PEEK_LD;
						end
					end
				endcase
			end
			S_POP_LD: begin
				// take the root out, move the last entry into the hole
				cmd.pop_init = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_PEEK_LD: begin
				cmd.peek_load = 1'b1;
				state_d       = S_FINISH;
			end
			S_INC_CMP: begin
				if (stat.key_smaller) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_SMALLER;
					state_d        = S_FINISH;
				end else begin
					cmd.inc_init = 1'b1;
					state_d      = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				if (stat.at_root) begin
					cmd.place = 1'b1;
					state_d   = S_FINISH;
				end else begin
					cmd.ra_sel = RA_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.parent_less) begin
					cmd.up_step = 1'b1;
					state_d     = S_UP_CHK;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_FINISH;
				end
			end
			S_DN_CHK: begin
				if (stat.down_leaf) begin
					cmd.place = 1'b1;
					state_d   = S_FINISH;
				end else begin
					cmd.ra_sel = RA_CHILD;
					state_d    = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.down_move) begin
					cmd.down_step = 1'b1;
					state_d       = S_DN_CHK;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the result register is free
				if (!rsp_valid_q || rsp_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
